// ===== hw/rtl/rc_pkg.sv =====
// Shared types and constants of the rank compressor.
`timescale 1ns / 1ps

package rc_pkg;

   localparam int VALUE_W = 32;
   localparam int RANK_W  = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STORE,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_WAIT
   } rc_state_type;

   // Outcome of one comparison of the new word against one held entry.
   typedef struct packed {
      logic [RANK_W-1:0] own_next;
      logic [RANK_W-1:0] count_next;
      logic              count_wr;
   } rc_cmp_res_type;

endpackage

// ===== hw/rtl/rc_req_if.sv =====
// Input channel of the rank compressor: one signed value and its last flag.
`timescale 1ns / 1ps

interface rc_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [rc_pkg::VALUE_W-1:0] value;
   logic                              last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== hw/rtl/rc_rsp_if.sv =====
// Result channel of the rank compressor: one rank with its flags.
`timescale 1ns / 1ps

interface rc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rc_pkg::RANK_W-1:0]  rank;
   logic                       overflow;
   logic                       final_res;

   modport source (output valid, output rank, output overflow, output final_res, input ready);
   modport sink   (input valid, input rank, input overflow, input final_res, output ready);
endinterface

// ===== hw/rtl/rank_compressor.sv =====
// Top level of the rank compressor: value and count memories, sequencer, result register.
`timescale 1ns / 1ps

// Loads a set of signed 32-bit words, one per accepted request word, until the word marked
// last, then returns for each stored word, in load order, the number of stored words that
// are strictly smaller. Words beyond MAX_ELEMENTS are dropped and every result of that set
// carries the overflow flag. A word loaded into a set that already holds words is compared
// with them before it is stored and ready returns (the first word of a set is stored at
// once): the held words are read one per cycle through the single read port of the value
// memory and checked by one shared signed comparator, the last comparison ends after the
// last read, and the store state writes the new word. A word dropped at a full store is
// neither compared nor stored. Each result then takes a memory read, a load of the output
// register and a response handshake. The request side is not ready meanwhile.
module rank_compressor #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   rc_req_if.sink      req_if,
   rc_rsp_if.source    rsp_if
);

   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   rc_pkg::rc_state_type state_ff, state_in;

   logic signed [rc_pkg::VALUE_W-1:0] new_value_ff, new_value_in;
   logic                              new_last_ff, new_last_in;
   logic [CNT_W-1:0]                  loaded_ff, loaded_in;
   logic                              overflow_ff, overflow_in;
   logic [CNT_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic                              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]                  cmp_idx_ff, cmp_idx_in;
   logic [rc_pkg::RANK_W-1:0]         own_ff, own_in;

   logic [rc_pkg::RANK_W-1:0]         rsp_rank_ff, rsp_rank_in;
   logic                              rsp_overflow_ff, rsp_overflow_in;
   logic                              rsp_final_ff, rsp_final_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Memories
   logic signed [rc_pkg::VALUE_W-1:0] value_mem [MAX_ELEMENTS];
   logic        [rc_pkg::RANK_W-1:0]  count_mem [MAX_ELEMENTS];
   logic signed [rc_pkg::VALUE_W-1:0] value_rd_ff;
   logic        [rc_pkg::RANK_W-1:0]  count_rd_ff;

   logic                              rd_en;
   logic [IDX_W-1:0]                  rd_addr;
   logic                              value_wr_en;
   logic                              count_wr_en;
   logic [IDX_W-1:0]                  value_wr_addr;
   logic [IDX_W-1:0]                  count_wr_addr;
   logic [rc_pkg::RANK_W-1:0]         count_wr_data;

   logic                              req_fire;
   logic                              rsp_fire;
   logic                              store_full;
   logic                              scan_done;
   rc_pkg::rc_cmp_res_type            cmp_res;

   assign req_if.ready     = (state_ff == rc_pkg::ST_IDLE);
   assign req_fire         = req_if.valid && req_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.rank      = rsp_rank_ff;
   assign rsp_if.overflow  = rsp_overflow_ff;
   assign rsp_if.final_res = rsp_final_ff;
   assign rsp_fire         = rsp_valid_ff && rsp_if.ready;

   assign store_full = (loaded_ff == CNT_W'(MAX_ELEMENTS));
   assign scan_done  = (rd_idx_ff == loaded_ff);
   assign rd_addr    = rd_idx_ff[IDX_W-1:0];
   assign rd_en      = (rd_idx_ff < loaded_ff) &&
                       ((state_ff == rc_pkg::ST_SCAN) || (state_ff == rc_pkg::ST_EMIT_RD));

   rc_cmp_unit u_cmp (
      .held_value (value_rd_ff),
      .new_value  (new_value_ff),
      .held_count (count_rd_ff),
      .own_count  (own_ff),
      .result     (cmp_res)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (store_full) begin
                  state_in = req_if.last ? rc_pkg::ST_EMIT_RD : rc_pkg::ST_IDLE;
               end else if (loaded_ff == '0) begin
                  state_in = rc_pkg::ST_STORE;
               end else begin
                  state_in = rc_pkg::ST_SCAN;
               end
            end
         end
         rc_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = rc_pkg::ST_STORE;
            end
         end
         rc_pkg::ST_STORE: begin
            state_in = new_last_ff ? rc_pkg::ST_EMIT_RD : rc_pkg::ST_IDLE;
         end
         rc_pkg::ST_EMIT_RD: begin
            state_in = rc_pkg::ST_EMIT_LD;
         end
         rc_pkg::ST_EMIT_LD: begin
            state_in = rc_pkg::ST_EMIT_WAIT;
         end
         rc_pkg::ST_EMIT_WAIT: begin
            if (rsp_fire) begin
               state_in = rsp_final_ff ? rc_pkg::ST_IDLE : rc_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = rc_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      new_value_in    = new_value_ff;
      new_last_in     = new_last_ff;
      loaded_in       = loaded_ff;
      overflow_in     = overflow_ff;
      rd_idx_in       = rd_idx_ff;
      cmp_valid_in    = 1'b0;
      cmp_idx_in      = rd_addr;
      own_in          = own_ff;
      rsp_rank_in     = rsp_rank_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_final_in    = rsp_final_ff;
      rsp_valid_in    = rsp_valid_ff;
      value_wr_en     = 1'b0;
      value_wr_addr   = loaded_ff[IDX_W-1:0];
      count_wr_en     = 1'b0;
      count_wr_addr   = cmp_idx_ff;
      count_wr_data   = cmp_res.count_next;

      case (state_ff)
         rc_pkg::ST_IDLE: begin
            if (req_fire) begin
               new_value_in = req_if.value;
               new_last_in  = req_if.last;
               rd_idx_in    = '0;
               own_in       = '0;
               if (store_full) begin
                  overflow_in = 1'b1;
               end
            end
         end
         rc_pkg::ST_SCAN: begin
            // Issue the next read while the previous entry is compared.
            if (!scan_done) begin
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
               cmp_valid_in = 1'b1;
            end
            if (cmp_valid_ff) begin
               own_in      = cmp_res.own_next;
               count_wr_en = cmp_res.count_wr;
            end
         end
         rc_pkg::ST_STORE: begin
            value_wr_en   = 1'b1;
            count_wr_en   = 1'b1;
            count_wr_addr = loaded_ff[IDX_W-1:0];
            count_wr_data = own_ff;
            loaded_in     = loaded_ff + CNT_W'(1);
            rd_idx_in     = '0;
         end
         rc_pkg::ST_EMIT_RD: begin
         end
         rc_pkg::ST_EMIT_LD: begin
            rsp_rank_in     = count_rd_ff;
            rsp_overflow_in = overflow_ff;
            rsp_final_in    = (rd_idx_ff + CNT_W'(1)) == loaded_ff;
            rsp_valid_in    = 1'b1;
         end
         rc_pkg::ST_EMIT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
               if (rsp_final_ff) begin
                  loaded_in   = '0;
                  overflow_in = 1'b0;
                  rd_idx_in   = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rc_pkg::ST_IDLE;
         loaded_ff    <= '0;
         overflow_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         overflow_ff  <= overflow_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_value_ff    <= new_value_in;
      new_last_ff     <= new_last_in;
      cmp_idx_ff      <= cmp_idx_in;
      own_ff          <= own_in;
      rsp_rank_ff     <= rsp_rank_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_final_ff    <= rsp_final_in;
   end

   // Value memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (value_wr_en) begin
         value_mem[value_wr_addr] <= new_value_ff;
      end
      if (rd_en) begin
         value_rd_ff <= value_mem[rd_addr];
      end
   end

   // Count memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (count_wr_en) begin
         count_mem[count_wr_addr] <= count_wr_data;
      end
      if (rd_en) begin
         count_rd_ff <= count_mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/rc_cmp_unit.sv =====
// Shared signed comparator that updates the running counts for one held entry.
`timescale 1ns / 1ps

module rc_cmp_unit (
   input  logic signed [rc_pkg::VALUE_W-1:0] held_value,
   input  logic signed [rc_pkg::VALUE_W-1:0] new_value,
   input  logic        [rc_pkg::RANK_W-1:0]  held_count,
   input  logic        [rc_pkg::RANK_W-1:0]  own_count,
   output rc_pkg::rc_cmp_res_type            result
);

   logic held_less;
   logic new_less;

   assign held_less = held_value < new_value;
   assign new_less  = new_value < held_value;

   always_comb begin
      result.own_next   = own_count;
      result.count_next = held_count + rc_pkg::RANK_W'(1);
      result.count_wr   = 1'b0;
      if (held_less) begin
         result.own_next = own_count + rc_pkg::RANK_W'(1);
      end else if (new_less) begin
         // The held entry now has one more smaller value beside it.
         result.count_wr = 1'b1;
      end
   end

endmodule

// ===== dv/rank_compressor_tb.sv =====
// Self-checking testbench of the rank compressor with directed and random sets.
`timescale 1ns / 1ps

module rank_compressor_tb;

   localparam int CAPACITY     = 64;
   localparam int WORD_TARGET  = 370;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int NO_PIN       = -1;

   typedef struct packed {
      logic [rc_pkg::RANK_W-1:0] rank;
      logic                      overflow;
      logic                      final_res;
   } rank_word_type;

   typedef struct packed {
      logic [rc_pkg::VALUE_W-1:0] value;
      bit                         last;
      int                         pinned;
   } stim_row_type;

   // Rows with a pinned rank have their expected rank typed in; the rest use the predictor.
   stim_row_type directed_rows [0:18] = '{
      '{32'h0000_0000, 1'b1, 0},
      '{32'h7FFF_FFFF, 1'b0, 3},
      '{32'h8000_0000, 1'b0, 0},
      '{32'hFFFF_FFFF, 1'b0, 1},
      '{32'h0000_0000, 1'b1, 2},
      '{32'd5,         1'b0, 0},
      '{32'd5,         1'b0, 0},
      '{32'd5,         1'b1, 0},
      '{32'd100,       1'b0, 2},
      '{32'd50,        1'b0, 1},
      '{32'hFFFF_FFCE, 1'b1, 0},
      '{32'hAAAA_AAAA, 1'b0, 0},
      '{32'h5555_5555, 1'b1, 1},
      '{32'd12345,     1'b0, NO_PIN},
      '{32'hFFFF_FFF9, 1'b0, NO_PIN},
      '{32'd12345,     1'b0, NO_PIN},
      '{32'h7FFF_FFFF, 1'b0, NO_PIN},
      '{32'h8000_0001, 1'b0, NO_PIN},
      '{32'h8000_0000, 1'b1, NO_PIN}
   };

   logic clock = 1'b0;
   logic reset;

   rc_req_if req_bus ();
   rc_rsp_if rsp_bus ();

   rank_compressor #(
      .MAX_ELEMENTS(CAPACITY)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #4 clock = ~clock;

   // Predictor state: the words held in the open set and their pinned ranks.
   logic signed [rc_pkg::VALUE_W-1:0] held_values [$];
   int                                held_pins [$];
   bit                                set_overflow = 1'b0;
   rank_word_type                     expected_ranks [$];

   int words_sent    = 0;
   int sets_closed   = 0;
   int overflow_sets = 0;
   int ranks_checked = 0;
   int mismatches    = 0;
   int idle_cycles   = 0;
   int burst_left    = 8;

   logic [31:0] stall_mask  = '1;
   logic [4:0]  stall_phase = '0;

   // The receiver follows a 32-bit stall mask, reloaded at random at each wrap.
   always @(posedge clock) begin
      if (stall_phase == 5'd0) begin
         if ($urandom_range(0, 3) == 0) begin
            stall_mask <= '1;
         end else begin
            stall_mask <= $urandom() | 32'h1;
         end
      end
      rsp_bus.ready <= stall_mask[stall_phase];
      stall_phase   <= stall_phase + 5'd1;
   end

   always @(posedge clock) begin
      rank_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         ranks_checked++;
         if (expected_ranks.size() == 0) begin
            $display("%0t: unexpected rank word: rank %0d overflow %0b final %0b", $time,
                     rsp_bus.rank, rsp_bus.overflow, rsp_bus.final_res);
            mismatches++;
         end else begin
            want = expected_ranks.pop_front();
            if (rsp_bus.rank !== want.rank) begin
               $display("%0t: rank expected %0d, got %0d", $time, want.rank, rsp_bus.rank);
               mismatches++;
            end
            if (rsp_bus.overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b, got %0b", $time, want.overflow,
                        rsp_bus.overflow);
               mismatches++;
            end
            if (rsp_bus.final_res !== want.final_res) begin
               $display("%0t: final_res expected %0b, got %0b", $time, want.final_res,
                        rsp_bus.final_res);
               mismatches++;
            end
         end
      end
      if (!reset && ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Drives one word, waits for it to be taken and updates the prediction.
   task automatic send_word(input logic signed [rc_pkg::VALUE_W-1:0] word, input bit last,
                            input int pinned);
      rank_word_type res;
      int            smaller;
      req_bus.valid <= 1'b1;
      req_bus.value <= word;
      req_bus.last  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      // A word arriving at a full store is dropped but still counts for the set.
      if (held_values.size() >= CAPACITY) begin
         set_overflow = 1'b1;
      end else begin
         held_values.push_back(word);
         held_pins.push_back(pinned);
      end
      if (last) begin
         for (int k = 0; k < held_values.size(); k++) begin
            smaller = 0;
            foreach (held_values[j]) begin
               if (held_values[j] < held_values[k]) smaller++;
            end
            res.rank      = (held_pins[k] >= 0) ? held_pins[k][rc_pkg::RANK_W-1:0]
                                                : smaller[rc_pkg::RANK_W-1:0];
            res.overflow  = set_overflow;
            res.final_res = (k == held_values.size() - 1);
            expected_ranks.push_back(res);
         end
         sets_closed++;
         if (set_overflow) overflow_sets++;
         held_values.delete();
         held_pins.delete();
         set_overflow = 1'b0;
      end
   endtask

   // Ends a burst with a random gap; a drain also holds off until all ranks are back.
   task automatic pace_sender(input bit drain);
      int gap;
      burst_left--;
      if (drain || burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         if (drain) begin
            while (expected_ranks.size() != 0) @(posedge clock);
         end
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   initial begin
      int                                set_index;
      int                                set_size;
      int                                mode;
      logic signed [rc_pkg::VALUE_W-1:0] word;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.last  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].value, directed_rows[i].last, directed_rows[i].pinned);
         pace_sender(i == $size(directed_rows) - 1);
      end

      // Random sets: mostly short, with a full set and two overflowing ones among them.
      set_index = 0;
      while (words_sent < WORD_TARGET) begin
         case (set_index)
            2:       set_size = CAPACITY;
            6:       set_size = CAPACITY + 1;
            11:      set_size = CAPACITY + 5;
            default: set_size = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 40)
                                                           : $urandom_range(1, 10);
         endcase
         mode = $urandom_range(0, 2);
         for (int i = 0; i < set_size; i++) begin
            case (mode)
               0: word = $urandom();
               1: word = $signed($urandom_range(0, 8)) - 4;
               default: begin
                  case ($urandom_range(0, 4))
                     0:       word = 32'sh7FFF_FFFF;
                     1:       word = 32'sh8000_0000;
                     2:       word = '0;
                     3:       word = -1;
                     default: word = $urandom();
                  endcase
               end
            endcase
            send_word(word, i == set_size - 1, NO_PIN);
            pace_sender((i == set_size - 1) && ($urandom_range(0, 4) == 0));
         end
         set_index++;
      end
      req_bus.valid <= 1'b0;

      while (expected_ranks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d sets from %0d words, %0d of them past capacity.", sets_closed,
               words_sent, overflow_sets);
      $display("Compared %0d rank words under random sender gaps and receiver stalls.",
               ranks_checked);
      if (mismatches == 0 && expected_ranks.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== rank_compressor.f =====
hw/rtl/rc_pkg.sv
hw/rtl/rc_req_if.sv
hw/rtl/rc_rsp_if.sv
hw/rtl/rc_cmp_unit.sv
hw/rtl/rank_compressor.sv
dv/rank_compressor_tb.sv
